/* src/ikarm_pkg.sv */
// shared constants, types and arctangent table for the two-link arm inverse kinematics
package ikarm_pkg;

  localparam int LINK_W     = 14;
  localparam int REACH_W    = LINK_W + 1;
  localparam int PRESCALE   = 20;
  localparam int Z_W        = 34;
  localparam int SHOULDER_W = 16;
  localparam int ELBOW_W    = 15;
  localparam int ROUND_SH   = 18;
  localparam int TABLE_LEN  = 24;

  localparam logic [LINK_W-1:0] LINK_RESET = 14'd5760;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] ROUND_BIAS  = 34'sd131072;

  typedef enum logic [0:0] {
    REG_LINK_ONE = 1'b0,
    REG_LINK_TWO = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic unreach;
    logic y_pos;
    logic acos_zero;
  } flags_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021687;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/ikarm_ifs.sv */
// valid/ready channel interfaces for targets and joint angles
interface ikarm_in_if #(parameter int COORD_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  modport source(output valid, output target_x, output target_y, input ready);
  modport sink(input valid, input target_x, input target_y, output ready);
endinterface

interface ikarm_out_if;
  logic valid;
  logic ready;
  logic signed [ikarm_pkg::SHOULDER_W-1:0] shoulder_angle;
  logic signed [ikarm_pkg::ELBOW_W-1:0]    elbow_angle;
  logic                                    unreachable;
  modport source(output valid, output shoulder_angle, output elbow_angle,
                 output unreachable, input ready);
  modport sink(input valid, input shoulder_angle, input elbow_angle,
               input unreachable, output ready);
endinterface

/* src/ikarm_sqrt_cell.sv */
// one root bit of a pipelined floor square root
module ikarm_sqrt_cell #(
  parameter int N  = 52,
  parameter int RT = 26
) (
  input  logic          clk,
  input  logic          en,
  input  logic [N-1:0]  rad_i,
  input  logic [RT+1:0] rem_i,
  input  logic [RT-1:0] root_i,
  output logic [N-1:0]  rad_o,
  output logic [RT+1:0] rem_o,
  output logic [RT-1:0] root_o
);

  logic [N-1:0]  rad_r;
  logic [RT+1:0] rem_r;
  logic [RT-1:0] root_r;
  logic [RT+1:0] rem_nxt;
  logic [RT-1:0] root_nxt;
  logic [RT+1:0] rem_sh;
  logic [RT+1:0] trial;

  always_comb begin
    rem_sh = {rem_i[RT-1:0], rad_i[N-1:N-2]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[RT-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[RT-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[N-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

/* src/ikarm_cordic_cell.sv */
// one vectoring micro-rotation of a pipelined cordic
module ikarm_cordic_cell #(
  parameter int W     = 40,
  parameter int STAGE = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [W-1:0]              x_i,
  input  logic signed [W-1:0]              y_i,
  input  logic signed [ikarm_pkg::Z_W-1:0] z_i,
  output logic signed [W-1:0]              x_o,
  output logic signed [W-1:0]              y_o,
  output logic signed [ikarm_pkg::Z_W-1:0] z_o
);

  localparam logic signed [ikarm_pkg::Z_W-1:0] ANG =
    ikarm_pkg::Z_W'(ikarm_pkg::atan_q30(STAGE));

  logic signed [W-1:0]              x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ikarm_pkg::Z_W-1:0] z_r, z_nxt;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!y_i[W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

/* src/two_link_arm_inverse_kinematics.sv */
// pipeline: input register, squares, distance checks, one square root cell per root bit
// (26 root bits at 16-bit coords), one cordic cell per stage, then the output register
// throughput: one word per cycle unless held; every sqrt and cordic cell advances together
// the whole row holds while an output word waits on out ready
// reset: synchronous active-low rst_n clears all valid bits, links return to 5760
module two_link_arm_inverse_kinematics #(
  parameter int COORD_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [0:0]                    cfg_index,
  input  logic [ikarm_pkg::LINK_W-1:0]  cfg_wdata,
  ikarm_in_if.sink                      in_ch,
  ikarm_out_if.source                   out_ch
);

  localparam int CW  = COORD_WIDTH;
  localparam int CS  = CORDIC_STAGES;
  localparam int LW  = ikarm_pkg::LINK_W;
  localparam int ZW  = ikarm_pkg::Z_W;
  localparam int PS  = ikarm_pkg::PRESCALE;
  localparam int DW  = (2 * CW > 31) ? 2 * CW : 31;
  localparam int N   = DW + PS + (DW % 2);
  localparam int RT  = N / 2;
  localparam int WA  = RT + PS + 3;
  localparam int WB  = CW + PS + 4;
  localparam int TOT = 3 + RT + CS;

  logic [LW-1:0] link_one_r, link_two_r;
  logic          en;
  logic [TOT-1:0] pipe_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_one_r <= ikarm_pkg::LINK_RESET;
      link_two_r <= ikarm_pkg::LINK_RESET;
    end else if (cfg_wr_en) begin
      case (ikarm_pkg::cfg_reg_t'(cfg_index))
        ikarm_pkg::REG_LINK_ONE: link_one_r <= cfg_wdata;
        ikarm_pkg::REG_LINK_TWO: link_two_r <= cfg_wdata;
        default: link_one_r <= link_one_r;
      endcase
    end
  end

  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pipe_v_r    <= {pipe_v_r[TOT-2:0], in_ch.valid};
      out_valid_r <= pipe_v_r[TOT-1];
    end
  end

  // input register
  logic signed [CW-1:0] s0_x_r, s0_y_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s0_x_r <= in_ch.target_x;
      s0_y_r <= in_ch.target_y;
    end
  end

  // squares
  logic signed [2*CW-1:0] xsq, ysq;
  logic [2*CW-1:0]        s1_xsq_r, s1_ysq_r;
  logic [ikarm_pkg::REACH_W-1:0] reach;
  logic [2*LW-1:0]        s1_l1sq_r;
  logic [2*ikarm_pkg::REACH_W-1:0] s1_reach2_r;
  logic signed [CW-1:0]   s1_x_r, s1_y_r;

  assign xsq   = s0_x_r * s0_x_r;
  assign ysq   = s0_y_r * s0_y_r;
  assign reach = {1'b0, link_one_r} + {1'b0, link_two_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xsq_r    <= xsq;
      s1_ysq_r    <= ysq;
      s1_l1sq_r   <= link_one_r * link_one_r;
      s1_reach2_r <= reach * reach;
      s1_x_r      <= s0_x_r;
      s1_y_r      <= s0_y_r;
    end
  end

  // distance, reach and ratio checks
  logic [DW-1:0]        d2, four_l1sq;
  logic [DW-1:0]        s2_d2_r, s2_diff_r;
  ikarm_pkg::flags_t    s2_flags_r, s2_flags_nxt;
  logic signed [CW-1:0] s2_x_r, s2_y_r;

  always_comb begin
    d2        = DW'(s1_xsq_r) + DW'(s1_ysq_r);
    four_l1sq = DW'({s1_l1sq_r, 2'b00});
    s2_flags_nxt.unreach   = (d2 == '0) || (d2 >= DW'(s1_reach2_r));
    s2_flags_nxt.y_pos     = !s1_y_r[CW-1] && (s1_y_r != '0);
    s2_flags_nxt.acos_zero = four_l1sq <= d2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d2_r    <= d2;
      s2_diff_r  <= s2_flags_nxt.acos_zero ? '0 : four_l1sq - d2;
      s2_flags_r <= s2_flags_nxt;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
    end
  end

  // square root rows
  logic [N-1:0]      pr_rad [RT+1];
  logic [RT+1:0]     pr_rem [RT+1];
  logic [RT-1:0]     pr_root[RT+1];
  logic [N-1:0]      qr_rad [RT+1];
  logic [RT+1:0]     qr_rem [RT+1];
  logic [RT-1:0]     qr_root[RT+1];
  ikarm_pkg::flags_t sq_flags_r[RT+1];
  logic signed [CW-1:0] sq_x_r[RT+1];
  logic signed [CW-1:0] sq_y_r[RT+1];

  assign pr_rad[0]     = N'(s2_d2_r) << PS;
  assign pr_rem[0]     = '0;
  assign pr_root[0]    = '0;
  assign qr_rad[0]     = N'(s2_diff_r) << PS;
  assign qr_rem[0]     = '0;
  assign qr_root[0]    = '0;
  assign sq_flags_r[0] = s2_flags_r;
  assign sq_x_r[0]     = s2_x_r;
  assign sq_y_r[0]     = s2_y_r;

  for (genvar k = 0; k < RT; k++) begin : g_sqrt
    ikarm_sqrt_cell #(.N(N), .RT(RT)) u_p (
      .clk(clk), .en(en),
      .rad_i(pr_rad[k]), .rem_i(pr_rem[k]), .root_i(pr_root[k]),
      .rad_o(pr_rad[k+1]), .rem_o(pr_rem[k+1]), .root_o(pr_root[k+1])
    );
    ikarm_sqrt_cell #(.N(N), .RT(RT)) u_q (
      .clk(clk), .en(en),
      .rad_i(qr_rad[k]), .rem_i(qr_rem[k]), .root_i(qr_root[k]),
      .rad_o(qr_rad[k+1]), .rem_o(qr_rem[k+1]), .root_o(qr_root[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sq_flags_r[k+1] <= sq_flags_r[k];
        sq_x_r[k+1]     <= sq_x_r[k];
        sq_y_r[k+1]     <= sq_y_r[k];
      end
    end
  end

  // cordic rows: acos from the two roots, base angle with quadrant pre-rotation
  logic signed [WA-1:0] ca_x[CS+1], ca_y[CS+1];
  logic signed [ZW-1:0] ca_z[CS+1];
  logic signed [WB-1:0] cb_x[CS+1], cb_y[CS+1];
  logic signed [ZW-1:0] cb_z[CS+1];
  ikarm_pkg::flags_t    cr_flags_r[CS+1];
  logic signed [WB-1:0] xs, ys;

  assign ca_x[0] = signed'({{(WA-RT){1'b0}}, pr_root[RT]}) <<< PS;
  assign ca_y[0] = signed'({{(WA-RT){1'b0}}, qr_root[RT]}) <<< PS;
  assign ca_z[0] = '0;
  assign xs = signed'({{(WB-CW){sq_x_r[RT][CW-1]}}, sq_x_r[RT]}) <<< PS;
  assign ys = signed'({{(WB-CW){sq_y_r[RT][CW-1]}}, sq_y_r[RT]}) <<< PS;
  assign cr_flags_r[0] = sq_flags_r[RT];

  always_comb begin
    if (sq_x_r[RT][CW-1] && !sq_y_r[RT][CW-1]) begin
      cb_x[0] = ys;
      cb_y[0] = -xs;
      cb_z[0] = ikarm_pkg::HALF_PI_Q30;
    end else if (sq_x_r[RT][CW-1]) begin
      cb_x[0] = -ys;
      cb_y[0] = xs;
      cb_z[0] = -ikarm_pkg::HALF_PI_Q30;
    end else begin
      cb_x[0] = xs;
      cb_y[0] = ys;
      cb_z[0] = '0;
    end
  end

  for (genvar j = 0; j < CS; j++) begin : g_cordic
    ikarm_cordic_cell #(.W(WA), .STAGE(j)) u_a (
      .clk(clk), .en(en),
      .x_i(ca_x[j]), .y_i(ca_y[j]), .z_i(ca_z[j]),
      .x_o(ca_x[j+1]), .y_o(ca_y[j+1]), .z_o(ca_z[j+1])
    );
    ikarm_cordic_cell #(.W(WB), .STAGE(j)) u_b (
      .clk(clk), .en(en),
      .x_i(cb_x[j]), .y_i(cb_y[j]), .z_i(cb_z[j]),
      .x_o(cb_x[j+1]), .y_o(cb_y[j+1]), .z_o(cb_z[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        cr_flags_r[j+1] <= cr_flags_r[j];
      end
    end
  end

  // joint angles and rounding to q4.12 shoulder and q3.12 elbow
  ikarm_pkg::flags_t fl;
  logic signed [ZW-1:0] acos_a, asin_a, shoulder_q30, elbow_q30, sh_rnd, el_rnd;
  logic signed [ikarm_pkg::SHOULDER_W-1:0] shoulder_r;
  logic signed [ikarm_pkg::ELBOW_W-1:0]    elbow_r;
  logic                                    unreach_r;

  always_comb begin
    fl     = cr_flags_r[CS];
    acos_a = fl.acos_zero ? '0 : ca_z[CS];
    asin_a = ikarm_pkg::HALF_PI_Q30 - acos_a;
    if (fl.y_pos) begin
      shoulder_q30 = cb_z[CS] - acos_a;
      elbow_q30    = -(asin_a <<< 1);
    end else begin
      shoulder_q30 = cb_z[CS] + acos_a;
      elbow_q30    = asin_a <<< 1;
    end
    sh_rnd = (shoulder_q30 + ikarm_pkg::ROUND_BIAS) >>> ikarm_pkg::ROUND_SH;
    el_rnd = (elbow_q30 + ikarm_pkg::ROUND_BIAS) >>> ikarm_pkg::ROUND_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shoulder_r <= fl.unreach ? '0 : sh_rnd[ikarm_pkg::SHOULDER_W-1:0];
      elbow_r    <= fl.unreach ? '0 : el_rnd[ikarm_pkg::ELBOW_W-1:0];
      unreach_r  <= fl.unreach;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.shoulder_angle = shoulder_r;
  assign out_ch.elbow_angle    = elbow_r;
  assign out_ch.unreachable    = unreach_r;

endmodule

/* src/ikarm_checker.sv */
// port-level checks for the two-link arm inverse kinematics, bound to the top level
module ikarm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ikarm_pkg::SHOULDER_W-1:0] shoulder_angle,
  input logic signed [ikarm_pkg::ELBOW_W-1:0]    elbow_angle,
  input logic                                unreachable
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(shoulder_angle)
      && $stable(elbow_angle) && $stable(unreachable))
    else $error("stalled output word changed");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && unreachable |-> shoulder_angle == '0 && elbow_angle == '0)
    else $error("unreachable word with nonzero angles");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output backpressure");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind two_link_arm_inverse_kinematics ikarm_checker u_ikarm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .shoulder_angle(out_ch.shoulder_angle),
  .elbow_angle(out_ch.elbow_angle),
  .unreachable(out_ch.unreachable)
);
